@@ rtl/core/smrq_pkg.sv @@
package smrq_pkg;

    localparam int CAPACITY = 1024;
    localparam int MAX_RANK = 8;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 60;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 2;

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int RIDX_W  = $clog2(MAX_RANK + 1);

    localparam int GRP  = 32;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT = 2'd0,
        F_BELOW  = 2'd1,
        F_ABOVE  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic              cmp;
        logic              shift;
        logic              below;
        logic              above;
        logic [KEY_W-1:0]  key;
        logic [RIDX_W-1:0] ridx;
    } t_cell_ctl;

endpackage

@@ rtl/core/smrq_if.sv @@
interface smrq_in_if import smrq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output func, output key, output rank, input ready);
    modport sink (input valid, input func, input key, input rank, output ready);
endinterface

interface smrq_out_if import smrq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_key;

    modport source (output valid, output status, output found_key, input ready);
    modport sink (input valid, input status, input found_key, output ready);
endinterface

@@ rtl/core/sorted_multiset_rank_query.sv @@
// Sorted multiset of 60-bit keys with rank-th neighbor queries.
// i_req carries func, key and rank; o_rsp returns status and found_key,
// one item out for every item in. Both are valid/ready channels.
// The keys sit in a row of CAPACITY cells in ascending order. In the cycle
// after an item is taken every cell compares its key with the item key;
// in the next cycle an insert shifts the cells above the insert point up
// by one, while a query lets each cell decide from the flags of its
// MAX_RANK neighbors whether it holds the answer and 32-cell groups OR
// the chosen key into a register. In S_RED the groups are merged into
// the output register. A new item is taken only once the last one has
// reached S_RED and the output register is free.
// If o_rsp is stalled the result waits in the merge stage; the block
// then holds i_req.ready low until the output register frees up.
// Reset empties the store (count to zero) and drops any pending result;
// no clearing pass is needed.
module sorted_multiset_rank_query import smrq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    smrq_in_if.sink    i_req,
    smrq_out_if.source o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SEL  = 4'b0100,
        S_RED  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [COUNT_W-1:0]  r_count;
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_W-1:0]    r_key;
    logic [RANK_W-1:0]   r_rank;
    logic                r_do_ins;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_found;

    logic                in_acc;
    logic                out_free;
    logic                rank_ok;
    t_cell_ctl           ctl;

    logic [CAPACITY-1:0]            occ;
    logic [CAPACITY-1:0]            le;
    logic [CAPACITY-1:0]            lt;
    logic [CAPACITY-1:0]            sel;
    logic [CAPACITY-1:0][KEY_W-1:0] keys;

    logic [NGRP-1:0]            grp_any;
    logic [NGRP-1:0][KEY_W-1:0] grp_key;
    logic                       any_sel;
    logic [KEY_W-1:0]           sel_key;
    logic [STATUS_W-1:0]        n_status;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) || ((r_state == S_RED) && out_free);
    assign in_acc = i_req.valid && i_req.ready;

    assign rank_ok = (r_rank != '0) && (32'(r_rank) <= MAX_RANK);

    always_comb begin
        ctl       = '0;
        ctl.cmp   = (r_state == S_CMP);
        ctl.shift = (r_state == S_SEL) && r_do_ins;
        ctl.below = (r_func == F_BELOW) && rank_ok;
        ctl.above = (r_func == F_ABOVE) && rank_ok;
        ctl.key   = r_key;
        ctl.ridx  = RIDX_W'(r_rank);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [MAX_RANK:0] le_win;
        logic [MAX_RANK:0] lt_win;

        assign occ[i] = (COUNT_W'(i) < r_count);

        for (genvar k = 0; k <= MAX_RANK; k++) begin : g_win
            if (i + k < CAPACITY) begin : g_le
                assign le_win[k] = le[i + k];
            end else begin : g_le_pad
                assign le_win[k] = 1'b0;
            end
            if (i - k >= 0) begin : g_lt
                assign lt_win[k] = lt[i - k];
            end else begin : g_lt_pad
                assign lt_win[k] = 1'b1;
            end
        end

        if (i == 0) begin : g_first
            smrq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occ      (occ[i]),
                .i_prev_key (r_key),
                .i_prev_le  (1'b1),
                .i_le_win   (le_win),
                .i_lt_win   (lt_win),
                .o_le       (le[i]),
                .o_lt       (lt[i]),
                .o_key      (keys[i]),
                .o_sel      (sel[i])
            );
        end else begin : g_rest
            smrq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occ      (occ[i]),
                .i_prev_key (keys[i - 1]),
                .i_prev_le  (le[i - 1]),
                .i_le_win   (le_win),
                .i_lt_win   (lt_win),
                .o_le       (le[i]),
                .o_lt       (lt[i]),
                .o_key      (keys[i]),
                .o_sel      (sel[i])
            );
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [GRP-1:0]            gsel;
        logic [GRP-1:0][KEY_W-1:0] gkey;

        for (genvar k = 0; k < GRP; k++) begin : g_lane
            if (g * GRP + k < CAPACITY) begin : g_real
                assign gsel[k] = sel[g * GRP + k];
                assign gkey[k] = keys[g * GRP + k];
            end else begin : g_pad
                assign gsel[k] = 1'b0;
                assign gkey[k] = '0;
            end
        end

        smrq_grp u_grp (
            .i_clk (i_clk),
            .i_en  (r_state == S_SEL),
            .i_sel (gsel),
            .i_key (gkey),
            .o_any (grp_any[g]),
            .o_key (grp_key[g])
        );
    end

    always_comb begin
        sel_key = '0;
        for (int g = 0; g < NGRP; g++) begin
            sel_key = sel_key | grp_key[g];
        end
    end
    assign any_sel = |grp_any;

    always_comb begin
        case (r_func)
            F_INSERT: n_status = r_do_ins ? ST_INSERTED : ST_FULL;
            F_BELOW,
            F_ABOVE:  n_status = any_sel ? ST_FOUND : ST_NOT_FOUND;
            default:  n_status = ST_NOT_FOUND;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_CMP;
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = S_RED;
            S_RED: begin
                if (out_free) begin
                    n_state = in_acc ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_SEL) && r_do_ins) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if ((r_state == S_RED) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_req.func;
            r_key  <= i_req.key;
            r_rank <= i_req.rank;
        end
        if (r_state == S_CMP) begin
            r_do_ins <= (r_func == F_INSERT) && (r_count != COUNT_W'(CAPACITY));
        end
        if ((r_state == S_RED) && out_free) begin
            r_status <= n_status;
            r_found  <= (n_status == ST_FOUND) ? sel_key : '0;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.found_key = r_found;

endmodule

@@ rtl/core/smrq_cell.sv @@
module smrq_cell import smrq_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_occ,
    input  logic [KEY_W-1:0]  i_prev_key,
    input  logic              i_prev_le,
    input  logic [MAX_RANK:0] i_le_win,
    input  logic [MAX_RANK:0] i_lt_win,
    output logic              o_le,
    output logic              o_lt,
    output logic [KEY_W-1:0]  o_key,
    output logic              o_sel
);

    logic              r_le;
    logic              r_lt;
    logic [KEY_W-1:0]  r_key;
    logic [RIDX_W-1:0] ridx_m1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_le <= i_occ && (r_key <= i_ctl.key);
            r_lt <= i_occ && (r_key < i_ctl.key);
        end
        // shift up behind the insert point, new key lands at the boundary
        if (i_ctl.shift && !r_le) begin
            r_key <= i_prev_le ? i_ctl.key : i_prev_key;
        end
    end

    assign ridx_m1 = i_ctl.ridx - RIDX_W'(1);

    assign o_sel = (i_ctl.below && i_le_win[ridx_m1] && !i_le_win[i_ctl.ridx])
                || (i_ctl.above && i_occ && i_lt_win[i_ctl.ridx] && !i_lt_win[ridx_m1]);

    assign o_le  = r_le;
    assign o_lt  = r_lt;
    assign o_key = r_key;

endmodule

@@ rtl/core/smrq_grp.sv @@
module smrq_grp import smrq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [GRP-1:0]            i_sel,
    input  logic [GRP-1:0][KEY_W-1:0] i_key,
    output logic                      o_any,
    output logic [KEY_W-1:0]          o_key
);

    logic             r_any;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    always_comb begin
        n_key = '0;
        for (int k = 0; k < GRP; k++) begin
            n_key = n_key | (i_key[k] & {KEY_W{i_sel[k]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_any <= |i_sel;
            r_key <= n_key;
        end
    end

    assign o_any = r_any;
    assign o_key = r_key;

endmodule

@@ rtl/core/smrq_chk.sv @@
module smrq_chk import smrq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [KEY_W-1:0]    i_found_key
);

    // reset drops any pending result
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item at a time: after an item is taken, i_in_ready stays low while it moves through compare and select
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("item taken while another is in flight");

    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_FOUND)) |-> (i_found_key == '0))
        else $error("found_key nonzero without a hit");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_found_key)))
        else $error("stalled result changed");

endmodule

bind sorted_multiset_rank_query smrq_chk u_smrq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found_key (o_rsp.found_key)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import smrq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
    localparam int N_ITEMS     = 1250;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        bit                drain_first;
    } t_req_item;

    typedef struct {
        t_status          status;
        logic [KEY_W-1:0] found_key;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smrq_in_if  req_if ();
    smrq_out_if rsp_if ();

    sorted_multiset_rank_query dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted contents of the store, ascending
    logic [KEY_W-1:0] stored_keys[$];
    t_answer          expected_answers[$];
    t_req_item        req_pending[$];

    // generation side
    logic [KEY_W-1:0] insert_history[$];
    logic [KEY_W-1:0] cluster[16];
    int               gen_fill;
    int               n_items;

    int n_accepted, n_checked, n_errors, n_cycles;
    int n_inserted, n_dropped, n_found, n_not_found;

    t_req_item drv_item;
    bit        drv_valid;
    int        gap_left;
    bit        mon_ready;
    int        stall_left;
    logic      hold_off;
    int        hold_left, hold_runs;

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] w = {$urandom, $urandom};
        return w[KEY_W-1:0];
    endfunction

    // number of stored keys below k, or at most k
    function automatic int keys_up_to(logic [KEY_W-1:0] k, bit inclusive);
        int lo = 0;
        int hi = stored_keys.size();
        int mid;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stored_keys[mid] < k || (inclusive && stored_keys[mid] == k))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic t_answer apply_to_store(t_req_item it);
        t_answer a;
        int      c;
        int      rk;
        a.status    = ST_NOT_FOUND;
        a.found_key = '0;
        rk          = int'(it.rank);
        if (it.func == F_INSERT) begin
            if (stored_keys.size() >= CAPACITY) begin
                a.status = ST_FULL;
            end else begin
                stored_keys.insert(keys_up_to(it.key, 1'b1), it.key);
                a.status = ST_INSERTED;
            end
        end else if ((it.func == F_BELOW || it.func == F_ABOVE)
                     && rk >= 1 && rk <= MAX_RANK) begin
            if (it.func == F_BELOW) begin
                c = keys_up_to(it.key, 1'b1);
                if (rk <= c) begin
                    a.found_key = stored_keys[c - rk];
                    a.status    = ST_FOUND;
                end
            end else begin
                c = keys_up_to(it.key, 1'b0);
                if (c + rk <= stored_keys.size()) begin
                    a.found_key = stored_keys[c + rk - 1];
                    a.status    = ST_FOUND;
                end
            end
        end
        case (a.status)
            ST_INSERTED: n_inserted++;
            ST_FULL:     n_dropped++;
            ST_FOUND:    n_found++;
            default:     n_not_found++;
        endcase
        return a;
    endfunction

    function automatic void add_item(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                     logic [RANK_W-1:0] rank, bit drain_first);
        t_req_item it;
        it.func        = func;
        it.key         = key;
        it.rank        = rank;
        it.drain_first = drain_first;
        if (func == F_INSERT) begin
            if (gen_fill < CAPACITY) gen_fill++;
            insert_history.insert(insert_history.size(), key);
        end
        req_pending.insert(req_pending.size(), it);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit for_query);
        int               r = $urandom_range(0, 99);
        logic [KEY_W-1:0] k;
        if (for_query && insert_history.size() > 0 && r < 50) begin
            k = insert_history[$urandom_range(0, insert_history.size() - 1)];
            case ($urandom_range(0, 2))
                0:       k = k - KEY_W'(1);
                2:       k = k + KEY_W'(1);
                default: ;
            endcase
        end else if (r < 70) begin
            k = cluster[$urandom_range(0, 15)] + KEY_W'($urandom_range(0, 3));
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       k = '0;
                1:       k = KEY_W'(1);
                2:       k = KEY_MAX - KEY_W'(1);
                default: k = KEY_MAX;
            endcase
        end else begin
            k = rand_key();
        end
        return k;
    endfunction

    task automatic build_directed();
        add_item(F_BELOW, 5, 1, 1'b0);
        add_item(F_ABOVE, 5, 1, 1'b0);
        add_item(F_INSERT, '0, 0, 1'b0);
        add_item(F_INSERT, KEY_MAX, 1, 1'b0);
        add_item(F_INSERT, 100, 2, 1'b0);
        add_item(F_INSERT, 100, 3, 1'b0);
        add_item(F_BELOW, KEY_MAX, 1, 1'b0);
        add_item(F_BELOW, 100, 2, 1'b0);
        add_item(F_BELOW, 100, 3, 1'b0);
        add_item(F_BELOW, 100, 4, 1'b0);
        add_item(F_BELOW, 99, 1, 1'b0);
        add_item(F_ABOVE, '0, 1, 1'b0);
        add_item(F_ABOVE, 1, 2, 1'b0);
        add_item(F_ABOVE, 101, 1, 1'b0);
        add_item(F_ABOVE, KEY_MAX, 2, 1'b0);
        add_item(F_BELOW, KEY_MAX, 0, 1'b0);
        add_item(F_ABOVE, '0, RANK_W'(MAX_RANK + 1), 1'b0);
        add_item(F_BELOW, KEY_MAX, 15, 1'b0);
        add_item(FUNC_UNUSED, 100, 1, 1'b0);
        add_item(F_INSERT, 100, 15, 1'b0);
        add_item(F_ABOVE, 100, 3, 1'b0);
        add_item(F_BELOW, KEY_MAX, RANK_W'(MAX_RANK), 1'b0);
        add_item(F_ABOVE, '0, RANK_W'(MAX_RANK), 1'b0);
    endtask

    task automatic build_random();
        int                n_directed = req_pending.size();
        int                extra_full = 0;
        int                r;
        logic [FUNC_W-1:0] func;
        logic [RANK_W-1:0] rank;
        for (int i = 0; i < 16; i++) begin
            cluster[i] = (i < 6) ? KEY_W'($urandom_range(0, 1000)) : rand_key();
        end
        cluster[0] = '0;
        cluster[1] = KEY_MAX - KEY_W'(3);
        while (req_pending.size() < N_ITEMS || extra_full < 60) begin
            r = $urandom_range(0, 99);
            if (gen_fill < CAPACITY) begin
                func = (r < 88) ? F_INSERT : (r < 93) ? F_BELOW
                     : (r < 98) ? F_ABOVE : FUNC_UNUSED;
            end else begin
                extra_full++;
                func = (r < 30) ? F_INSERT : (r < 62) ? F_BELOW
                     : (r < 95) ? F_ABOVE : FUNC_UNUSED;
            end
            rank = ($urandom_range(0, 99) < 85) ? RANK_W'($urandom_range(1, MAX_RANK))
                                                 : RANK_W'($urandom_range(0, 15));
            add_item(func, pick_key(func != F_INSERT), rank,
                     req_pending.size() == n_directed || req_pending.size() == 700);
        end
    endtask

    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", n_checked, msg);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            drv_valid = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                expected_answers.insert(expected_answers.size(), apply_to_store(drv_item));
                n_accepted++;
                drv_valid = 1'b0;
            end
            if (!drv_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_pending.size() > 0 &&
                             !(req_pending[0].drain_first && expected_answers.size() > 0)) begin
                    drv_item = req_pending.pop_front();
                    req_if.func <= drv_item.func;
                    req_if.key  <= drv_item.key;
                    req_if.rank <= drv_item.rank;
                    drv_valid   = 1'b1;
                    gap_left    = ((n_accepted / 150) % 4 == 1) ? 0 : pick_gap();
                end
            end
            req_if.valid <= drv_valid;
        end
    end

    // response monitor and checker
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_checked++;
                if (expected_answers.size() == 0) begin
                    note_error($sformatf("unexpected item, status %0d key %h",
                                         rsp_if.status, rsp_if.found_key));
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (rsp_if.status !== exp_a.status
                        || rsp_if.found_key !== exp_a.found_key)
                        note_error($sformatf("status exp %0d got %0d, key exp %h got %h",
                                             exp_a.status, rsp_if.status,
                                             exp_a.found_key, rsp_if.found_key));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                mon_ready = 1'b0;
            end else if ((n_cycles / 600) % 4 != 3 && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
                mon_ready  = 1'b0;
            end else begin
                mon_ready = 1'b1;
            end
            rsp_if.ready <= mon_ready && !hold_off;
        end
    end

    // long receiver hold so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 1'b0;
            hold_left = 0;
            hold_runs = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_off <= 1'b0;
        end else if (hold_runs < 2 && n_accepted >= 200 + 800 * hold_runs) begin
            hold_left = HOLD_CYCLES;
            hold_runs++;
            hold_off <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items accepted, %0d pending",
                     n_cycles, n_accepted, n_items, expected_answers.size());
            $display("[sorted_multiset_rank_query] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.func  = F_INSERT;
        req_if.key   = '0;
        req_if.rank  = '0;
        rsp_if.ready = 1'b0;
        hold_off     = 1'b0;
        build_directed();
        build_random();
        n_items = req_pending.size();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < n_items || expected_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d items: %0d inserts, %0d dropped on a full store, %0d found, %0d not found",
                 n_accepted, n_inserted, n_dropped, n_found, n_not_found);
        $display("%0d results checked, %0d mismatches, %0d cycles",
                 n_checked, n_errors, n_cycles);
        if (n_errors == 0) begin
            $display("[sorted_multiset_rank_query] OK");
        end else begin
            $display("[sorted_multiset_rank_query] ERROR");
        end
        $finish;
    end

endmodule
